### rtl/core/gsds_pkg.sv
// Shared types, constants and the reciprocal table for the gaussian density core.
package gsds_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRAP,
		ST_OFFS,
		ST_SQ,
		ST_ARG,
		ST_CUT,
		ST_EXP,
		ST_TERM,
		ST_WGT,
		ST_GRAD,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		REG_CENTRE_X,
		REG_CENTRE_Y,
		REG_CENTRE_Z_OFFSET,
		REG_BOX_X,
		REG_BOX_Y,
		REG_BOX_Z,
		REG_SLAB_HALF_WIDTH,
		REG_INV_SIGMA_SQ
	} reg_index_t;

	localparam logic [28:0] EXP_NEG1_Q30   = 29'd395007542;
	localparam logic [64:0] ARG_CUTOFF_X2  = 65'd1572864;
	localparam logic [31:0] INV_SIGMA_RST  = 32'd65536;
	localparam logic [3:0]  TERM_COUNT     = 4'd12;
	localparam int          DATA_W         = 152;

	// floor(2^32 / k) for the series divisor k
	function automatic logic [32:0] recip_k(input logic [3:0] k);
		logic [32:0] r;
		case (k)
			4'd1:    r = 33'h1_0000_0000;
			4'd2:    r = 33'h0_8000_0000;
			4'd3:    r = 33'h0_5555_5555;
			4'd4:    r = 33'h0_4000_0000;
			4'd5:    r = 33'h0_3333_3333;
			4'd6:    r = 33'h0_2AAA_AAAA;
			4'd7:    r = 33'h0_2492_4924;
			4'd8:    r = 33'h0_2000_0000;
			4'd9:    r = 33'h0_1C71_C71C;
			4'd10:   r = 33'h0_1999_9999;
			4'd11:   r = 33'h0_1745_D174;
			4'd12:   r = 33'h0_1555_5555;
			default: r = 33'h0;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/gaussian_sphere_density_sum.sv
// Gaussian slab-sphere density core with periodic wrap and running frame sum.
//
//   channel | direction | handshake          | contents
//   s_axis  | in        | tvalid/tready      | atom position, tlast = final atom
//   m_axis  | out       | tvalid/tready      | weight, gradient, total; tuser = selected
//   cfg     | in        | cfg_valid/ready    | register index and value
//
// One atom at a time: input is taken only in idle. Atoms outside the slab, or whose
// argument hits the cutoff, skip to the last step; a weight that rounds to zero skips
// the gradient. The result appears as the core turns ready again. n = integer part of
// the argument, 0 to 11. Work: 3 squares, 2 scaling products, n exponent steps, 12 series
// terms of 3 products each, 9 gradient products, all on one 33x33 multiplier.
// Reset clears control, registers and the frame sum; no clearing pass.
// A finished result holds in the output register; the core stalls in its last step
// only when that register is still full.
module gaussian_sphere_density_sum
	import gsds_pkg::*;
#(
	parameter int MAX_ATOMS = 65536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [95:0]         s_axis_tdata,  // pos_x, pos_y, pos_z
	input  logic                s_axis_tlast,  // final_atom
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [DATA_W-1:0]   m_axis_tdata,  // weight, grad_x, grad_y, grad_z, running_total
	output logic                m_axis_tuser,  // selected
	output logic                m_axis_tlast,  // frame_done
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam logic [32:0] CAP = 33'(MAX_ATOMS) << 16;

	state_t state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic [1:0] ph_q, ph_d;

	logic signed [31:0] centre_x_q, centre_y_q, centre_z_offset_q;
	logic [30:0] box_x_q, box_y_q, box_z_q, slab_half_width_q;
	logic [31:0] inv_sigma_sq_q;
	logic [32:0] acc_q;

	logic signed [31:0] px_q, py_q, pz_q;
	logic last_q, sel_q;
	logic signed [33:0] pwx_q, pwy_q, cz_q;
	logic [31:0] cmag_q [3];
	logic [2:0] dneg_q, dzero_q;
	logic [63:0] d2_q;
	logic [64:0] s_q;
	logic [30:0] e_q;
	logic [32:0] term_q;
	logic [31:0] y_q, q0_q;
	logic signed [35:0] sum_q;
	logic [16:0] w_q;
	logic [63:0] p_q, g_q;
	logic [31:0] grad_q [3];

	logic m_valid_q, m_user_q, m_last_q;
	logic [DATA_W-1:0] m_data_q;

	logic [32:0] mul_a, mul_b;
	logic [65:0] mul_p;
	logic in_acc, out_load;
	logic [3:0] n_w;

	logic signed [34:0] px2, py2, cx2, cy2, bx35, by35, pz35, hw35, cz35;
	logic signed [33:0] pwx_w, pwy_w, cz_w;
	logic sel_w;
	logic signed [34:0] dx_w, dy_w, dz_w;
	logic [34:0] ax_w, ay_w, az_w;
	logic [32:0] sumc_w;
	logic [16:0] w_w;
	logic [63:0] gsum_w;
	logic [31:0] m_w, gr_w;
	logic [31:0] r_w;
	logic [31:0] q_w;
	logic [33:0] tot_w;
	logic [32:0] totc_w;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign out_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
	assign n_w           = s_q[20:17];
	assign mul_p         = mul_a * mul_b;

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	always_comb begin
		px2   = 35'(px_q) <<< 1;
		py2   = 35'(py_q) <<< 1;
		cx2   = 35'(centre_x_q) <<< 1;
		cy2   = 35'(centre_y_q) <<< 1;
		bx35  = $signed({4'b0, box_x_q});
		by35  = $signed({4'b0, box_y_q});
		pz35  = 35'(pz_q);
		hw35  = $signed({4'b0, slab_half_width_q});
		cz_w  = 34'(centre_z_offset_q) + $signed({4'b0, box_z_q[30:1]});
		cz35  = 35'(cz_w);
		sel_w = (cz35 - hw35 < pz35) && (pz35 < cz35 + hw35);
		if (px2 < cx2 - bx35)      pwx_w = 34'(px_q) + $signed({3'b0, box_x_q});
		else if (px2 > cx2 + bx35) pwx_w = 34'(px_q) - $signed({3'b0, box_x_q});
		else                       pwx_w = 34'(px_q);
		if (py2 < cy2 - by35)      pwy_w = 34'(py_q) + $signed({3'b0, box_y_q});
		else if (py2 > cy2 + by35) pwy_w = 34'(py_q) - $signed({3'b0, box_y_q});
		else                       pwy_w = 34'(py_q);
		dx_w = 35'(pwx_q) - 35'(centre_x_q);
		dy_w = 35'(pwy_q) - 35'(centre_y_q);
		dz_w = pz35 - 35'(cz_q);
		ax_w = dx_w[34] ? 35'(-dx_w) : 35'(dx_w);
		ay_w = dy_w[34] ? 35'(-dy_w) : 35'(dy_w);
		az_w = dz_w[34] ? 35'(-dz_w) : 35'(dz_w);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQ: begin
				mul_a = {1'b0, cmag_q[cnt_q[1:0]]};
				mul_b = {1'b0, cmag_q[cnt_q[1:0]]};
			end
			ST_ARG: begin
				mul_a = cnt_q[0] ? {1'b0, d2_q[63:32]} : {1'b0, d2_q[31:0]};
				mul_b = {1'b0, inv_sigma_sq_q};
			end
			ST_EXP: begin
				mul_a = {2'b0, e_q};
				mul_b = {4'b0, EXP_NEG1_Q30};
			end
			ST_TERM: begin
				case (ph_q)
					2'd0: begin
						mul_a = term_q;
						mul_b = {17'b0, s_q[16:1]};
					end
					2'd1: begin
						mul_a = {1'b0, y_q};
						mul_b = recip_k(cnt_q);
					end
					default: begin
						mul_a = {1'b0, q0_q};
						mul_b = {29'b0, cnt_q};
					end
				endcase
			end
			ST_WGT: begin
				mul_a = {2'b0, e_q};
				mul_b = sumc_w;
			end
			ST_GRAD: begin
				case (ph_q)
					2'd0: begin
						mul_a = {1'b0, cmag_q[cnt_q[1:0]]};
						mul_b = {1'b0, inv_sigma_sq_q};
					end
					2'd1: begin
						mul_a = {16'b0, w_q};
						mul_b = {1'b0, p_q[31:0]};
					end
					default: begin
						mul_a = {16'b0, w_q};
						mul_b = {1'b0, p_q[63:32]};
					end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		if (sum_q < 0)                         sumc_w = '0;
		else if (sum_q > 36'sh1_0000_0000)     sumc_w = 33'h1_0000_0000;
		else                                   sumc_w = sum_q[32:0];
		w_w    = 17'((mul_p[62:0] + 63'h2000_0000_0000) >> 46);
		r_w    = y_q - mul_p[31:0];
		q_w    = q0_q + 32'(r_w >= {28'b0, cnt_q});
		gsum_w = g_q + {mul_p[31:0], 32'b0};
		m_w    = 32'((gsum_w + 64'h8000_0000) >> 32);
		if (m_w > 32'h8000_0000) m_w = 32'h8000_0000;
		if (dzero_q[cnt_q[1:0]])      gr_w = '0;
		else if (!dneg_q[cnt_q[1:0]]) gr_w = -m_w;
		else if (m_w[31])             gr_w = 32'h7FFF_FFFF;
		else                          gr_w = m_w;
		tot_w  = {1'b0, acc_q} + {17'b0, w_q};
		totc_w = (tot_w > {1'b0, CAP}) ? CAP : tot_w[32:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ph_q    <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			ph_q    <= ph_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ph_d    = ph_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_WRAP;
			ST_WRAP: state_d = ST_OFFS;
			ST_OFFS: begin
				cnt_d   = '0;
				state_d = sel_q ? ST_SQ : ST_DONE;
			end
			ST_SQ: begin
				if (cnt_q == 4'd2) begin
					cnt_d   = '0;
					state_d = ST_ARG;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			ST_ARG: begin
				if (cnt_q[0]) state_d = ST_CUT;
				cnt_d = cnt_q + 4'd1;
			end
			ST_CUT: begin
				cnt_d   = '0;
				state_d = (s_q >= ARG_CUTOFF_X2) ? ST_DONE : ST_EXP;
			end
			ST_EXP: begin
				if (cnt_q == n_w) begin
					cnt_d   = 4'd1;
					ph_d    = '0;
					state_d = ST_TERM;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			ST_TERM: begin
				if (ph_q == 2'd2) begin
					ph_d = '0;
					if (cnt_q == TERM_COUNT) state_d = ST_WGT;
					else cnt_d = cnt_q + 4'd1;
				end else begin
					ph_d = ph_q + 2'd1;
				end
			end
			ST_WGT: begin
				cnt_d   = '0;
				ph_d    = '0;
				state_d = (w_w == '0) ? ST_DONE : ST_GRAD;
			end
			ST_GRAD: begin
				if (ph_q == 2'd2) begin
					ph_d = '0;
					if (cnt_q == 4'd2) state_d = ST_DONE;
					else cnt_d = cnt_q + 4'd1;
				end else begin
					ph_d = ph_q + 2'd1;
				end
			end
			ST_DONE: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_x_q        <= '0;
			centre_y_q        <= '0;
			centre_z_offset_q <= '0;
			box_x_q           <= '0;
			box_y_q           <= '0;
			box_z_q           <= '0;
			slab_half_width_q <= '0;
			inv_sigma_sq_q    <= INV_SIGMA_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_CENTRE_X:        centre_x_q        <= cfg_data;
				REG_CENTRE_Y:        centre_y_q        <= cfg_data;
				REG_CENTRE_Z_OFFSET: centre_z_offset_q <= cfg_data;
				REG_BOX_X:           box_x_q           <= cfg_data[30:0];
				REG_BOX_Y:           box_y_q           <= cfg_data[30:0];
				REG_BOX_Z:           box_z_q           <= cfg_data[30:0];
				REG_SLAB_HALF_WIDTH: slab_half_width_q <= cfg_data[30:0];
				REG_INV_SIGMA_SQ:    inv_sigma_sq_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_acc) begin
				px_q   <= s_axis_tdata[31:0];
				py_q   <= s_axis_tdata[63:32];
				pz_q   <= s_axis_tdata[95:64];
				last_q <= s_axis_tlast;
				w_q    <= '0;
				for (int i = 0; i < 3; i++) grad_q[i] <= '0;
			end
			ST_WRAP: begin
				pwx_q <= pwx_w;
				pwy_q <= pwy_w;
				cz_q  <= cz_w;
				sel_q <= sel_w;
			end
			ST_OFFS: begin
				cmag_q[0] <= (ax_w > 35'h8000_0000) ? 32'h8000_0000 : ax_w[31:0];
				cmag_q[1] <= (ay_w > 35'h8000_0000) ? 32'h8000_0000 : ay_w[31:0];
				cmag_q[2] <= (az_w > 35'h8000_0000) ? 32'h8000_0000 : az_w[31:0];
				dneg_q    <= {dz_w[34], dy_w[34], dx_w[34]};
				dzero_q   <= {dz_w == '0, dy_w == '0, dx_w == '0};
				d2_q      <= '0;
			end
			ST_SQ: d2_q <= d2_q + mul_p[63:0];
			ST_ARG: begin
				if (cnt_q[0]) s_q <= s_q + mul_p[64:0];
				else          s_q <= {33'b0, mul_p[63:32]};
			end
			ST_CUT: begin
				e_q    <= 31'h4000_0000;
				term_q <= 33'h1_0000_0000;
				sum_q  <= 36'sh1_0000_0000;
			end
			ST_EXP: if (cnt_q != n_w) e_q <= 31'((mul_p[59:0] + 60'h2000_0000) >> 30);
			ST_TERM: begin
				case (ph_q)
					2'd0: y_q  <= mul_p[47:16];
					2'd1: q0_q <= mul_p[63:32];
					default: begin
						term_q <= {1'b0, q_w};
						if (cnt_q[0]) sum_q <= sum_q - $signed({4'b0, q_w});
						else          sum_q <= sum_q + $signed({4'b0, q_w});
					end
				endcase
			end
			ST_WGT: w_q <= w_w;
			ST_GRAD: begin
				case (ph_q)
					2'd0:    p_q <= mul_p[63:0];
					2'd1:    g_q <= mul_p[63:0];
					default: grad_q[cnt_q[1:0]] <= gr_w;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			acc_q     <= last_q ? '0 : totc_w;
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {6'b0, totc_w, grad_q[2], grad_q[1], grad_q[0], w_q};
			m_user_q <= sel_q;
			m_last_q <= last_q;
		end
	end

	a_take_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken while core busy");

	a_rise_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside final step");

	a_unsel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[112:0] == '0))
		else $error("unselected atom with nonzero weight or gradient");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[16:0] <= 17'h10000))
		else $error("weight above one");

	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[145:113] <= CAP))
		else $error("running total above cap");

endmodule

### test/tb_gaussian_sphere_density_sum.sv
// Self-checking testbench for the gaussian slab-sphere density core.
`timescale 1ns / 100ps

module tb_gaussian_sphere_density_sum;
	import gsds_pkg::*;

	localparam int  WATCHDOG_LIMIT = 4000;
	localparam int  SETTLE_CYCLES  = 100;
	localparam int  RANDOM_ITEMS   = 1700;
	localparam longint SUM_CAP     = 64'd4294967296;

	typedef struct {
		bit        sel;
		bit [16:0] weight;
		bit [31:0] gx;
		bit [31:0] gy;
		bit [31:0] gz;
		bit [32:0] total;
		bit        done;
	} density_t;

	typedef struct {
		int        cfg_set;
		bit [31:0] x;
		bit [31:0] y;
		bit [31:0] z;
		bit        is_last;
		bit        known;
		bit        sel;
		bit [16:0] weight;
		bit [32:0] total;
	} atom_row_t;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [95:0]        s_axis_tdata;
	logic               s_axis_tlast;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [DATA_W-1:0]  m_axis_tdata;
	logic               m_axis_tuser;
	logic               m_axis_tlast;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;

	density_t  density_q[$];
	bit [31:0] reg_file[8];
	bit [32:0] density_acc;
	int        errors;
	bit        no_idle;
	bit        hold_req;
	int        hold_cnt;
	int        stall_cnt;

	gaussian_sphere_density_sum uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint sx32(bit [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic bit [63:0] abs64(longint d);
		return d < 0 ? 64'(-d) : 64'(d);
	endfunction

	function automatic longint wrap_offset(longint p, longint c, longint box);
		if (2 * p < 2 * c - box) p += box;
		else if (2 * p > 2 * c + box) p -= box;
		return p - c;
	endfunction

	function automatic bit [63:0] kernel_weight(bit [63:0] arg);
		bit [63:0] n, f, e, term;
		longint acc;
		e = 64'd1 << 30;
		term = 64'd1 << 32;
		acc = longint'(64'd1 << 32);
		if (arg >= (64'd12 << 16)) return 0;
		n = arg >> 16;
		f = arg & 64'hFFFF;
		for (int i = 0; i < 11; i++)
			if (i < n) e = (e * 64'd395007542 + (64'd1 << 29)) >> 30;
		for (int i = 1; i <= 12; i++) begin
			term = (term * f) / (64'(i) << 16);
			if (i & 1) acc -= longint'(term);
			else acc += longint'(term);
		end
		if (acc < 0) acc = 0;
		if (acc > longint'(64'd1 << 32)) acc = longint'(64'd1 << 32);
		return (e * 64'(acc) + (64'd1 << 45)) >> 46;
	endfunction

	function automatic bit [31:0] grad_component(bit [63:0] w, longint d);
		bit [63:0] m;
		longint g;
		if (w == 0) return 0;
		m = (w * (abs64(d) * 64'(reg_file[REG_INV_SIGMA_SQ])) + (64'd1 << 31)) >> 32;
		if (m > 64'd2147483648) m = 64'd2147483648;
		g = d > 0 ? -longint'(m) : longint'(m);
		if (d == 0) g = 0;
		if (g > 64'sd2147483647) g = 64'sd2147483647;
		return g[31:0];
	endfunction

	function automatic density_t predict_density(bit [31:0] x, bit [31:0] y, bit [31:0] z,
			bit is_last);
		density_t r;
		longint px, py, pz, cz, hw, dx, dy, dz;
		bit [63:0] cx, cy, cc, d2, hi, lo, s, w, inv, tot;
		px = sx32(x);
		py = sx32(y);
		pz = sx32(z);
		cz = sx32(reg_file[REG_CENTRE_Z_OFFSET]) + longint'(reg_file[REG_BOX_Z] >> 1);
		hw = longint'(reg_file[REG_SLAB_HALF_WIDTH]);
		inv = 64'(reg_file[REG_INV_SIGMA_SQ]);
		r = '{default: 0};
		r.sel = (cz - hw < pz) && (pz < cz + hw);
		w = 0;
		if (r.sel) begin
			dx = wrap_offset(px, sx32(reg_file[REG_CENTRE_X]), longint'(reg_file[REG_BOX_X]));
			dy = wrap_offset(py, sx32(reg_file[REG_CENTRE_Y]), longint'(reg_file[REG_BOX_Y]));
			dz = pz - cz;
			cx = abs64(dx);
			cy = abs64(dy);
			cc = abs64(dz);
			if (cx > (64'd1 << 31)) cx = 64'd1 << 31;
			if (cy > (64'd1 << 31)) cy = 64'd1 << 31;
			if (cc > (64'd1 << 31)) cc = 64'd1 << 31;
			d2 = cx * cx + cy * cy + cc * cc;
			hi = d2 >> 32;
			lo = d2 & 64'hFFFF_FFFF;
			s = hi * inv + ((lo * inv) >> 32);
			w = kernel_weight(s >> 1);
			r.gx = grad_component(w, dx);
			r.gy = grad_component(w, dy);
			r.gz = grad_component(w, dz);
		end
		r.weight = w[16:0];
		tot = 64'(density_acc) + w;
		if (tot > SUM_CAP) tot = SUM_CAP;
		r.total = tot[32:0];
		r.done = is_last;
		density_acc = is_last ? 33'd0 : tot[32:0];
		return r;
	endfunction

	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic write_reg(reg_index_t idx, bit [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		reg_file[idx] = (idx >= REG_BOX_X && idx <= REG_SLAB_HALF_WIDTH) ?
			(value & 32'h7FFF_FFFF) : value;
	endtask

	task automatic write_all(bit [31:0] v[8]);
		for (int i = 0; i < 8; i++) write_reg(reg_index_t'(i), v[i]);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (density_q.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_atom(bit [31:0] x, bit [31:0] y, bit [31:0] z, bit is_last,
			bit known, density_t typed);
		int gap;
		density_t r;
		gap = idle_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {z, y, x};
		s_axis_tlast  <= is_last;
		do @(posedge clk); while (!s_axis_tready);
		r = predict_density(x, y, z, is_last);
		density_q.push_back(known ? typed : r);
	endtask

	task automatic apply_directed_set(int k);
		bit [31:0] v[8];
		case (k)
			1: v = '{32'd0, 32'd0, 32'd0, 32'd655360, 32'd655360, 32'd655360,
				32'd131072, 32'd0};
			2: v = '{32'd0, 32'd0, 32'd0, 32'd655360, 32'd655360, 32'd655360,
				32'd131072, 32'd65536};
			default: v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd65536, 32'd0, 32'd0, 32'd0,
				32'h7FFF_FFFF, 32'hFFFF_FFFF};
		endcase
		write_all(v);
	endtask

	task automatic apply_random_set(int k);
		bit [31:0] v[8];
		int r;
		for (int i = 0; i < 3; i++)
			v[i] = ($urandom_range(0, 3) == 0) ? $urandom :
				32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
		for (int i = 3; i < 6; i++) begin
			r = $urandom_range(0, 9);
			v[i] = r == 0 ? 32'd0 : r == 1 ? 32'hFFFF_FFFF :
				r < 4 ? $urandom : $urandom_range(32'h0001_0000, 32'h0100_0000);
		end
		r = $urandom_range(0, 9);
		v[6] = r == 0 ? 32'd0 : r == 1 ? 32'h7FFF_FFFF : $urandom_range(1, 32'h0008_0000);
		r = $urandom_range(0, 9);
		v[7] = r == 0 ? 32'd0 : r == 1 ? 32'hFFFF_FFFF : r == 2 ? $urandom :
			$urandom_range(1, 32'h0004_0000);
		if (k == 0) v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1};
		write_all(v);
	endtask

	function automatic bit [31:0] near_coord(bit [31:0] c, bit [31:0] box);
		longint p;
		p = sx32(c) + longint'($urandom_range(0, 32'h0008_0000)) - 64'sd262144;
		case ($urandom_range(0, 5))
			0: p += longint'(box);
			1: p -= longint'(box);
			default: ;
		endcase
		return p[31:0];
	endfunction

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			density_t a, e;
			a.sel    = m_axis_tuser;
			a.weight = m_axis_tdata[16:0];
			a.gx     = m_axis_tdata[48:17];
			a.gy     = m_axis_tdata[80:49];
			a.gz     = m_axis_tdata[112:81];
			a.total  = m_axis_tdata[145:113];
			a.done   = m_axis_tlast;
			if (density_q.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				e = density_q.pop_front();
				if (a.sel != e.sel) begin
					$error("selected: expected %0d, got %0d", e.sel, a.sel); errors++;
				end
				if (a.weight != e.weight) begin
					$error("weight: expected %0d, got %0d", e.weight, a.weight); errors++;
				end
				if (a.gx != e.gx) begin
					$error("grad_x: expected %h, got %h", e.gx, a.gx); errors++;
				end
				if (a.gy != e.gy) begin
					$error("grad_y: expected %h, got %h", e.gy, a.gy); errors++;
				end
				if (a.gz != e.gz) begin
					$error("grad_z: expected %h, got %h", e.gz, a.gz); errors++;
				end
				if (a.total != e.total) begin
					$error("running_total: expected %0d, got %0d", e.total, a.total); errors++;
				end
				if (a.done != e.done) begin
					$error("frame_done: expected %0d, got %0d", e.done, a.done); errors++;
				end
			end
		end
		if (hold_req) begin
			hold_req = 1'b0;
			hold_cnt = 600;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else if (no_idle) begin
			m_axis_tready <= 1'b1;
		end else begin
			if ($urandom_range(0, 199) == 0) hold_cnt = $urandom_range(10, 50);
			m_axis_tready <= $urandom_range(0, 9) < 7;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			stall_cnt = 0;
		else if (++stall_cnt >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		atom_row_t rows[$];
		density_t typed;
		int cur_set;
		int frame_len;
		bit [31:0] x, y, z;
		errors = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		hold_cnt = 0;
		stall_cnt = 0;
		density_acc = 0;
		reg_file = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, INV_SIGMA_RST};
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rows = '{
			'{0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 1'b0, 17'd0, 33'd0},
			'{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 17'd0, 33'd0},
			'{0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 1'b0, 17'd0, 33'd0},
			'{1, 32'd0, 32'd0, 32'd327680, 1'b0, 1'b1, 1'b1, 17'd65536, 33'd65536},
			'{1, 32'd1000, -32'd1000, 32'd327780, 1'b0, 1'b1, 1'b1, 17'd65536, 33'd131072},
			'{1, 32'd0, 32'd0, 32'd458752, 1'b0, 1'b1, 1'b0, 17'd0, 33'd131072},
			'{1, 32'd0, 32'd0, 32'd196608, 1'b1, 1'b1, 1'b0, 17'd0, 33'd131072},
			'{1, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1, 1'b0, 17'd0, 33'd0},
			'{2, 32'd0, 32'd0, 32'd327680, 1'b0, 1'b0, 1'b0, 17'd0, 33'd0},
			'{2, 32'd30000, -32'd20000, 32'd340000, 1'b0, 1'b0, 1'b0, 17'd0, 33'd0},
			'{2, 32'd393216, 32'd0, 32'd327680, 1'b0, 1'b0, 1'b0, 17'd0, 33'd0},
			'{2, 32'd0, -32'd393216, 32'd327680, 1'b0, 1'b0, 1'b0, 17'd0, 33'd0},
			'{2, 32'd131072, 32'd131072, 32'd400000, 1'b0, 1'b0, 1'b0, 17'd0, 33'd0},
			'{2, 32'd200000, 32'd200000, 32'd327680, 1'b0, 1'b0, 1'b0, 17'd0, 33'd0},
			'{2, 32'h7FFF_FFFF, 32'h8000_0000, 32'd327680, 1'b1, 1'b0, 1'b0, 17'd0, 33'd0},
			'{3, 32'h7FFF_FFFF, 32'h8000_0000, 32'd65536, 1'b0, 1'b0, 1'b0, 17'd0, 33'd0},
			'{3, 32'h7FFF_FF00, 32'h8000_0100, 32'd65600, 1'b0, 1'b0, 1'b0, 17'd0, 33'd0},
			'{3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 17'd0, 33'd0},
			'{3, 32'd0, 32'd0, 32'h8000_0001, 1'b1, 1'b0, 1'b0, 17'd0, 33'd0}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cur_set = 0;
		foreach (rows[i]) begin
			if (rows[i].cfg_set != cur_set) begin
				s_axis_tvalid <= 1'b0;
				wait_drained();
				cur_set = rows[i].cfg_set;
				apply_directed_set(cur_set);
			end
			typed = '{rows[i].sel, rows[i].weight, 32'd0, 32'd0, 32'd0, rows[i].total,
				rows[i].is_last};
			send_atom(rows[i].x, rows[i].y, rows[i].z, rows[i].is_last, rows[i].known, typed);
		end
		for (int ph = 0; ph < 8; ph++) begin
			s_axis_tvalid <= 1'b0;
			wait_drained();
			apply_random_set(ph);
			no_idle = (ph == 3);
			for (int n = 0; n < RANDOM_ITEMS / 8; n++) begin
				if (ph == 2 && n == 20) hold_req = 1'b1;
				frame_len = $urandom_range(0, 15);
				if ($urandom_range(0, 4) == 0) begin
					x = $urandom;
					y = $urandom;
					z = $urandom;
				end else begin
					x = near_coord(reg_file[REG_CENTRE_X], reg_file[REG_BOX_X]);
					y = near_coord(reg_file[REG_CENTRE_Y], reg_file[REG_BOX_Y]);
					z = 32'(sx32(reg_file[REG_CENTRE_Z_OFFSET]) +
						longint'(reg_file[REG_BOX_Z] >> 1) +
						longint'($urandom_range(0, 32'h0010_0000)) - 64'sd524288);
				end
				send_atom(x, y, z, frame_len == 0, 1'b0, typed);
			end
		end
		s_axis_tvalid <= 1'b0;
		wait_drained();
		if (density_q.size() != 0) errors++;
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
